### design/assert_macros.svh
// assertion macros shared by the frame receiver rtl
// every macro samples on aclk and is disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_AT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

### design/cfr_pkg.sv
// shared types and constants of the checksummed frame receiver
// no dependencies
package cfr_pkg;

    localparam int PAYLOAD_LEN   = 8;
    localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_LEN);
    localparam int BYTE_IDX_W    = 4;
    localparam int SEARCH_W      = 9;
    localparam int MISS_W        = 5;

    localparam logic [BYTE_IDX_W-1:0] CHECK_IDX = BYTE_IDX_W'(PAYLOAD_LEN);
    localparam logic [BYTE_IDX_W-1:0] LAST_IDX  = BYTE_IDX_W'(PAYLOAD_LEN + 1);
    localparam logic [MISS_W-1:0]     MISS_SAT  = MISS_W'(16);

    localparam logic [7:0] SYNC_BYTE_RST    = 8'hAF;
    localparam logic [7:0] END_BYTE_RST     = 8'hED;
    localparam logic [7:0] SEARCH_LIMIT_RST = 8'd10;
    localparam logic [3:0] MISS_LIMIT_RST   = 4'd4;

    typedef enum logic [1:0] {
        REG_SYNC_BYTE    = 2'd0,
        REG_END_BYTE     = 2'd1,
        REG_SEARCH_LIMIT = 2'd2,
        REG_MISS_LIMIT   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        FAIL_NONE  = 2'd0,
        FAIL_SYNC  = 2'd1,
        FAIL_FRAME = 2'd2
    } fail_kind_t;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [7:0] end_byte;
        logic [7:0] search_limit;
        logic [3:0] miss_limit;
    } cfg_t;

    typedef struct packed {
        logic              frame_ok;
        fail_kind_t        fail_kind;
        logic              emergency_stop;
        logic [MISS_W-1:0] failure_count;
    } status_t;

    typedef logic [PAYLOAD_LEN-1:0][7:0] payload_t;

endpackage

### design/checksummed_frame_receiver_core.sv
// top level of the checksummed frame receiver: handshakes, config registers, result register
// depends on cfr_pkg, cfr_frame_fsm and assert_macros.svh
// a transferred byte goes to the input register, and its result to the result register driving m_valid
// throughput: one byte per cycle, set by the frame update between the
// input register and the result register; a stalled result blocks only once both are full
// reset: synchronous active-low aresetn clears handshake and frame state and loads
// the register defaults; the payload store has no reset and needs no clearing pass
`include "assert_macros.svh"

module checksummed_frame_receiver_core (
    input  logic       aclk,
    input  logic       aresetn,

    // received byte channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,

    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_left_x,
    output logic [7:0] m_left_y,
    output logic [7:0] m_right_x,
    output logic [7:0] m_right_y,
    output logic [7:0] m_trigger_left,
    output logic [7:0] m_trigger_right,
    output logic [7:0] m_buttons_a,
    output logic [7:0] m_buttons_b,
    output logic       m_frame_ok,
    output logic [1:0] m_fail_kind,
    output logic       m_emergency_stop,
    output logic [4:0] m_failure_count,

    // register write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import cfr_pkg::*;

    // config registers
    cfg_t       cfg_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // result register
    logic       out_valid_reg;
    payload_t   out_payload_reg;
    status_t    out_status_reg;

    // frame logic hookup
    logic       proc_en;
    logic       res_valid;
    payload_t   res_payload;
    status_t    res_status;

    // a buffered byte moves on once the result slot is empty or being drained
    assign proc_en   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_en;
    assign cfg_ready = 1'b1;

    // register writes, each index maps to one field
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_byte    <= SYNC_BYTE_RST;
            cfg_reg.end_byte     <= END_BYTE_RST;
            cfg_reg.search_limit <= SEARCH_LIMIT_RST;
            cfg_reg.miss_limit   <= MISS_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                REG_SYNC_BYTE:    cfg_reg.sync_byte    <= cfg_data;
                REG_END_BYTE:     cfg_reg.end_byte     <= cfg_data;
                REG_SEARCH_LIMIT: cfg_reg.search_limit <= cfg_data;
                REG_MISS_LIMIT:   cfg_reg.miss_limit   <= cfg_data[3:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // input register, refilled on every transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    cfr_frame_fsm u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (proc_en),
        .rx_byte     (in_byte_reg),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res_payload (res_payload),
        .res_status  (res_status)
    );

    // result register: loaded when a byte completes something, cleared on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_en) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_en && res_valid) begin
            out_payload_reg <= res_payload;
            out_status_reg  <= res_status;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_left_x         = out_payload_reg[0];
    assign m_left_y         = out_payload_reg[1];
    assign m_right_x        = out_payload_reg[2];
    assign m_right_y        = out_payload_reg[3];
    assign m_trigger_left   = out_payload_reg[4];
    assign m_trigger_right  = out_payload_reg[5];
    assign m_buttons_a      = out_payload_reg[6];
    assign m_buttons_b      = out_payload_reg[7];
    assign m_frame_ok       = out_status_reg.frame_ok;
    assign m_fail_kind      = out_status_reg.fail_kind;
    assign m_emergency_stop = out_status_reg.emergency_stop;
    assign m_failure_count  = out_status_reg.failure_count;

    // a good frame clears the failure count and reports no failure
    `ASSERT_AT(a_ok_clears, m_valid && m_frame_ok |-> (m_fail_kind == FAIL_NONE) && (m_failure_count == '0), "good frame with failure status")
    // emergency stop needs at least one recorded failure
    `ASSERT_AT(a_stop_needs_fail, m_valid && m_emergency_stop |-> m_failure_count != '0, "stop with zero failures")
    // a failed result always carries a failure kind
    `ASSERT_AT(a_fail_has_kind, m_valid && !m_frame_ok |-> (m_fail_kind == FAIL_SYNC) || (m_fail_kind == FAIL_FRAME), "failure without kind")

endmodule

### design/cfr_frame_fsm.sv
// frame state, payload capture, checksum and failure counter
// depends on cfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module cfr_frame_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  cfr_pkg::cfg_t     cfg,
    output logic              res_valid,
    output cfr_pkg::payload_t res_payload,
    output cfr_pkg::status_t  res_status
);
    import cfr_pkg::*;

    logic                  collecting_reg, collecting_next;
    logic [BYTE_IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [SEARCH_W-1:0]   search_count_reg, search_count_next;
    logic [7:0]            running_sum_reg, running_sum_next;
    logic                  sum_matched_reg, sum_matched_next;
    logic [MISS_W-1:0]     miss_count_reg, miss_count_next;
    payload_t              payload_store_reg;

    logic                  emit;
    logic                  with_payload;
    logic                  ok;
    fail_kind_t            kind;
    logic                  store_we;
    logic [SEARCH_W-1:0]   search_inc;

    assign search_inc = search_count_reg + SEARCH_W'(1);

    always_comb begin
        collecting_next   = collecting_reg;
        byte_index_next   = byte_index_reg;
        search_count_next = search_count_reg;
        running_sum_next  = running_sum_reg;
        sum_matched_next  = sum_matched_reg;
        emit              = 1'b0;
        with_payload      = 1'b0;
        ok                = 1'b0;
        kind              = FAIL_NONE;
        store_we          = 1'b0;
        if (!collecting_reg) begin
            if (rx_byte == cfg.sync_byte) begin
                collecting_next   = 1'b1;
                byte_index_next   = '0;
                running_sum_next  = '0;
                sum_matched_next  = 1'b0;
                search_count_next = '0;
            end else if (search_inc > {1'b0, cfg.search_limit}) begin
                search_count_next = '0;
                emit              = 1'b1;
                kind              = FAIL_SYNC;
            end else begin
                search_count_next = search_inc;
            end
        end else if (byte_index_reg < CHECK_IDX) begin
            store_we         = 1'b1;
            running_sum_next = running_sum_reg + rx_byte;
            byte_index_next  = byte_index_reg + BYTE_IDX_W'(1);
        end else if (byte_index_reg == CHECK_IDX) begin
            sum_matched_next = (rx_byte == running_sum_reg);
            byte_index_next  = byte_index_reg + BYTE_IDX_W'(1);
        end else begin
            collecting_next   = 1'b0;
            byte_index_next   = '0;
            search_count_next = '0;
            emit              = 1'b1;
            with_payload      = 1'b1;
            ok                = sum_matched_reg && (rx_byte == cfg.end_byte);
            kind              = ok ? FAIL_NONE : FAIL_FRAME;
        end
    end

    // saturating count of consecutive failures
    always_comb begin
        miss_count_next = miss_count_reg;
        if (emit) begin
            if (ok) begin
                miss_count_next = '0;
            end else if (miss_count_reg < MISS_SAT) begin
                miss_count_next = miss_count_reg + MISS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg   <= 1'b0;
            byte_index_reg   <= '0;
            search_count_reg <= '0;
            running_sum_reg  <= '0;
            sum_matched_reg  <= 1'b0;
            miss_count_reg   <= '0;
        end else if (step) begin
            collecting_reg   <= collecting_next;
            byte_index_reg   <= byte_index_next;
            search_count_reg <= search_count_next;
            running_sum_reg  <= running_sum_next;
            sum_matched_reg  <= sum_matched_next;
            miss_count_reg   <= miss_count_next;
        end
    end

    // payload bytes, written in frame order
    always_ff @(posedge aclk) begin
        if (step && store_we) begin
            payload_store_reg[byte_index_reg[PAYLOAD_IDX_W-1:0]] <= rx_byte;
        end
    end

    assign res_valid                 = step && emit;
    assign res_payload               = with_payload ? payload_store_reg : '0;
    assign res_status.frame_ok       = ok;
    assign res_status.fail_kind      = kind;
    assign res_status.emergency_stop = (miss_count_next > {1'b0, cfg.miss_limit});
    assign res_status.failure_count  = miss_count_next;

    `ASSERT_NEVER(a_index_range, byte_index_reg > LAST_IDX, "byte index past end byte")
    `ASSERT_AT(a_hunt_index_zero, !collecting_reg |-> byte_index_reg == '0, "index set while hunting")
    `ASSERT_NEVER(a_miss_sat, miss_count_reg > MISS_SAT, "failure count above saturation")

endmodule

### sim/tb.sv
// self-checking testbench for checksummed_frame_receiver_core
// depends on cfr_pkg and the receiver rtl; random bytes come from the simulator seed
`timescale 1ns / 100ps

module tb;
    import cfr_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int DRAIN_PAUSE = 6;     // margin after the last expected result
    localparam int QUIET_LIMIT = 4000;  // cycles with no transfer on any channel
    localparam int HOLD_CYCLES = 120;   // long result back-pressure stretch

    typedef struct packed {
        payload_t payload;
        status_t  status;
    } frame_report_t;

    // frame predictor plus the queue of reports it still waits for
    class frame_report_checker;
        logic [7:0]        sync_val   = SYNC_BYTE_RST;
        logic [7:0]        end_val    = END_BYTE_RST;
        logic [7:0]        search_max = SEARCH_LIMIT_RST;
        logic [3:0]        miss_max   = MISS_LIMIT_RST;

        bit                in_frame   = 1'b0;
        logic [3:0]        pos        = '0;
        logic [8:0]        hunt_len   = '0;
        payload_t          bytes      = '0;
        logic [7:0]        sum        = '0;
        bit                sum_good   = 1'b0;
        logic [MISS_W-1:0] fails      = '0;

        frame_report_t     awaited[$];
        int unsigned       mistakes   = 0;
        string payload_names[PAYLOAD_LEN] = '{"left_x", "left_y", "right_x", "right_y",
                                              "trigger_left", "trigger_right",
                                              "buttons_a", "buttons_b"};

        function void apply_reg(cfg_index_t idx, logic [7:0] v);
            case (idx)
                REG_SYNC_BYTE:    sync_val   = v;
                REG_END_BYTE:     end_val    = v;
                REG_SEARCH_LIMIT: search_max = v;
                REG_MISS_LIMIT:   miss_max   = v[3:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void post_report(bit with_payload, bit ok, fail_kind_t kind);
            frame_report_t r;
            r.payload = with_payload ? bytes : '0;
            if (ok) begin
                fails = '0;
            end else if (fails < MISS_SAT) begin
                fails = fails + 1'b1;
            end
            r.status.frame_ok       = ok;
            r.status.fail_kind      = kind;
            r.status.emergency_stop = (fails > MISS_W'(miss_max));
            r.status.failure_count  = fails;
            awaited.push_back(r);
        endfunction

        // one accepted byte through the frame state machine
        function void take_rx_byte(logic [7:0] b);
            bit good;
            if (!in_frame) begin
                if (b == sync_val) begin
                    in_frame = 1'b1;
                    pos      = '0;
                    sum      = '0;
                    sum_good = 1'b0;
                    hunt_len = '0;
                end else begin
                    hunt_len = hunt_len + 1'b1;
                    if (hunt_len > {1'b0, search_max}) begin
                        hunt_len = '0;
                        post_report(1'b0, 1'b0, FAIL_SYNC);
                    end
                end
            end else if (pos < CHECK_IDX) begin
                bytes[pos[PAYLOAD_IDX_W-1:0]] = b;
                sum = sum + b;
                pos = pos + 1'b1;
            end else if (pos == CHECK_IDX) begin
                sum_good = (b == sum);
                pos = pos + 1'b1;
            end else begin
                in_frame = 1'b0;
                pos      = '0;
                hunt_len = '0;
                good     = sum_good && (b == end_val);
                post_report(1'b1, good, good ? FAIL_NONE : FAIL_FRAME);
            end
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mistakes++;
            end
        endfunction

        function void check_report(frame_report_t got);
            frame_report_t want;
            int i;
            if (awaited.size() == 0) begin
                $error("result transfer with no frame report expected");
                mistakes++;
                return;
            end
            want = awaited.pop_front();
            for (i = 0; i < PAYLOAD_LEN; i++)
                compare_field(payload_names[i], want.payload[i], got.payload[i]);
            compare_field("frame_ok", 8'(want.status.frame_ok), 8'(got.status.frame_ok));
            compare_field("fail_kind", 8'(want.status.fail_kind), 8'(got.status.fail_kind));
            compare_field("emergency_stop", 8'(want.status.emergency_stop),
                          8'(got.status.emergency_stop));
            compare_field("failure_count", 8'(want.status.failure_count),
                          8'(got.status.failure_count));
        endfunction
    endclass

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // byte channel into the block
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = '0;

    // result channel out of the block
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_left_x, m_left_y, m_right_x, m_right_y;
    logic [7:0] m_trigger_left, m_trigger_right, m_buttons_a, m_buttons_b;
    logic       m_frame_ok;
    logic [1:0] m_fail_kind;
    logic       m_emergency_stop;
    logic [4:0] m_failure_count;

    // register write channel
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = REG_SYNC_BYTE;
    logic [7:0] cfg_data  = '0;

    frame_report_checker board;
    frame_report_t       seen_report;
    int unsigned         bytes_sent   = 0;
    int unsigned         quiet_cycles = 0;
    bit                  calm         = 1'b0;  // no idling on either side while set
    bit                  hold_request = 1'b0;
    int                  hold_left    = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    checksummed_frame_receiver_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_x         (m_left_x),
        .m_left_y         (m_left_y),
        .m_right_x        (m_right_x),
        .m_right_y        (m_right_y),
        .m_trigger_left   (m_trigger_left),
        .m_trigger_right  (m_trigger_right),
        .m_buttons_a      (m_buttons_a),
        .m_buttons_b      (m_buttons_b),
        .m_frame_ok       (m_frame_ok),
        .m_fail_kind      (m_fail_kind),
        .m_emergency_stop (m_emergency_stop),
        .m_failure_count  (m_failure_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // result side: random back-pressure, with one long hold when asked for
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            m_ready      <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_request <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    // check every result transfer against the oldest predicted report
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_report.payload = {m_buttons_b, m_buttons_a, m_trigger_right, m_trigger_left,
                                   m_right_y, m_right_x, m_left_y, m_left_x};
            seen_report.status.frame_ok       = m_frame_ok;
            seen_report.status.fail_kind      = fail_kind_t'(m_fail_kind);
            seen_report.status.emergency_stop = m_emergency_stop;
            seen_report.status.failure_count  = m_failure_count;
            board.check_report(seen_report);
        end
    end

    // watchdog: cycles in a row with no transfer on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("tb: FAIL");
        $finish;
    end

    // one byte transfer; valid stays up afterwards so the next byte can follow directly
    task automatic send_byte(logic [7:0] b);
        while (!calm && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        board.take_rx_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] non_sync_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == board.sync_val);
        return b;
    endfunction

    // sync, payload, checksum and end byte, optionally corrupted
    task automatic send_frame(payload_t body, bit bad_sum, bit bad_end);
        logic [7:0] sum;
        int i;
        sum = '0;
        for (i = 0; i < PAYLOAD_LEN; i++) sum = sum + body[i];
        send_byte(board.sync_val);
        for (i = 0; i < PAYLOAD_LEN; i++) send_byte(body[i]);
        send_byte(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
        send_byte(bad_end ? board.end_val ^ 8'($urandom_range(1, 255)) : board.end_val);
    endtask

    // mostly well-formed frames, mixed with broken frames, hunting runs and raw noise
    task automatic send_random_traffic(int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        int unsigned broken;
        payload_t    body;
        int i;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            for (i = 0; i < PAYLOAD_LEN; i++)
                body[i] = ($urandom_range(7) == 0) ? board.sync_val : 8'($urandom);
            if (pick < 60) begin
                send_frame(body, 1'b0, 1'b0);
            end else if (pick < 75) begin
                broken = $urandom_range(1, 3);
                send_frame(body, broken[0], broken[1]);
            end else if (pick < 90) begin
                // hunting run, long enough at times to trip the search limit
                len = (board.search_max <= 30) ? $urandom_range(1, board.search_max + 2)
                                               : $urandom_range(1, 20);
                repeat (len) send_byte(non_sync_byte());
            end else begin
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
            end
        end
    endtask

    // let the block drain so registers only change while it is idle
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        board.apply_reg(idx, v);
    endtask

    task automatic configure(logic [7:0] sync_v, logic [7:0] end_v,
                             logic [7:0] search_v, logic [3:0] miss_v);
        settle();
        write_reg(REG_SYNC_BYTE, sync_v);
        write_reg(REG_END_BYTE, end_v);
        write_reg(REG_SEARCH_LIMIT, search_v);
        write_reg(REG_MISS_LIMIT, {4'b0, miss_v});
        cfg_valid <= 1'b0;
    endtask

    initial begin
        board = new;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values: good frame with extreme payload bytes that wraps the sum
        send_frame({8'hAA, 8'h55, 8'hFE, 8'h01, 8'h7F, 8'h80, 8'hFF, 8'h00}, 1'b0, 1'b0);
        // sync value inside the payload is plain data, bad checksum
        send_frame({8'h12, SYNC_BYTE_RST, 8'h34, 8'h56, SYNC_BYTE_RST, 8'h9C, 8'h3E, 8'hC1},
                   1'b1, 1'b0);
        send_random_traffic(180);

        // zero limits: every hunting byte fails, count saturates, stop raised at once
        configure(8'h00, 8'hFF, 8'h00, 4'd0);
        repeat (17) send_byte(non_sync_byte());
        send_frame('0, 1'b0, 1'b0);
        // long result hold while bytes keep coming, so the block fills and stalls
        hold_request <= 1'b1;
        send_random_traffic(180);

        // top limits: a sync failure only after 256 hunting bytes, no idling meanwhile
        configure(8'hFF, 8'h00, 8'hFF, 4'd15);
        calm = 1'b1;
        repeat (276) send_byte(non_sync_byte());
        send_random_traffic(40);
        calm = 1'b0;
        send_random_traffic(110);

        // random settings
        repeat (3) begin
            configure(8'($urandom), 8'($urandom), 8'($urandom_range(0, 20)),
                      4'($urandom_range(0, 15)));
            send_random_traffic(180);
        end

        settle();
        if (board.mistakes == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/cfr_pkg.sv
design/cfr_frame_fsm.sv
design/checksummed_frame_receiver_core.sv
sim/tb.sv
